FILE: design/elcu_pkg.sv
package elcu_pkg;

  // Field widths of the request and response words
  localparam int REQ_W  = 3;
  localparam int CL_W   = 2;
  localparam int EV_W   = 4;
  localparam int VAL_W  = 16;
  localparam int RD_W   = 16;
  localparam int LINE_W = 16;

  // Block configuration
  localparam int CLIENTS      = 4;
  localparam int EVENTS       = 12;
  localparam int HSYNC_EVENT  = 9;
  localparam int VSYNC_EVENT  = 10;
  localparam int FINISH_EVENT = 8;
  localparam int CNT_W        = 16;

  localparam int EV_AW = $clog2(EVENTS);
  localparam int CL_AW = $clog2(CLIENTS);

  typedef enum logic [REQ_W-1:0] {
    REQ_EVENT        = 3'd0,
    REQ_SET_MASK     = 3'd1,
    REQ_TAKE_FLAGS   = 3'd2,
    REQ_TAKE_COUNT   = 3'd3,
    REQ_CLEAR_COUNTS = 3'd4,
    REQ_SET_LINE     = 3'd5,
    REQ_READ_LINE    = 3'd6
  } req_e;

  // One counter memory row: the counters of all clients for one event
  typedef logic [CLIENTS-1:0][CNT_W-1:0] row_t;

endpackage

FILE: design/elcu_req_if.sv
interface elcu_req_if import elcu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [CL_W-1:0]  client;
  logic [EV_W-1:0]  event_id;
  logic             store_busy;
  logic [VAL_W-1:0] value;

  modport source (
    output valid, req_type, client, event_id, store_busy, value,
    input  ready
  );

  modport sink (
    input  valid, req_type, client, event_id, store_busy, value,
    output ready
  );
endinterface

FILE: design/elcu_rsp_if.sv
interface elcu_rsp_if import elcu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RD_W-1:0]    read_data;
  logic               error;
  logic [CLIENTS-1:0] latched_clients;
  logic [CLIENTS-1:0] pending_clients;

  modport source (
    output valid, read_data, error, latched_clients, pending_clients,
    input  ready
  );

  modport sink (
    input  valid, read_data, error, latched_clients, pending_clients,
    output ready
  );
endinterface

FILE: design/event_latch_counter_unit_top.sv
// Throughput: one word per cycle while the response side is not stalled; the counter
// memory row is read at acceptance and written back when the word moves on to the
// response register, with the write data forwarded to a following word that reads
// the same row.
// Reset (async, active low) clears masks, flags, line settings, the line counter and
// the counter valid bits at once; no clearing pass, words are taken right after reset.
module event_latch_counter_unit_top import elcu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  elcu_req_if.sink   req_i,
  elcu_rsp_if.source rsp_o
);

  typedef struct packed {
    req_e             req;
    logic [CL_W-1:0]  client;
    logic [EV_W-1:0]  ev;
    logic             busy;
    logic [VAL_W-1:0] val;
  } item_t;

  // Counter memory, one row per event
  row_t cnt_mem [EVENTS];
  row_t rd_row_q;
  row_t fwd_row_q;
  logic fwd_q;

  logic  s1_valid_q;
  item_t s1_item_q;

  logic [CLIENTS-1:0][EVENTS-1:0] mask_q, mask_d;
  logic [CLIENTS-1:0][EVENTS-1:0] flags_q, flags_d;
  logic [CLIENTS-1:0][LINE_W-1:0] match_q, match_d;
  logic [LINE_W-1:0]              line_q, line_d;
  logic [EVENTS-1:0][CLIENTS-1:0] cvalid_q, cvalid_d;

  logic               rsp_valid_q;
  logic [RD_W-1:0]    rsp_rd_q;
  logic               rsp_err_q;
  logic [CLIENTS-1:0] rsp_lat_q;
  logic [CLIENTS-1:0] rsp_pend_q;

  logic               accept;
  logic               advance;
  logic               in_ev_ok;
  logic [EV_AW-1:0]   in_addr;

  row_t               eff_row;
  row_t               wr_row;
  logic               wr_en;
  logic               ev_ok;
  logic               have;
  logic [EV_AW-1:0]   ea;
  logic [CL_AW-1:0]   ca;
  logic [EVENTS-1:0]  any_en;
  logic [EVENTS-1:0]  new_mask;
  logic [EVENTS-1:0]  diff;
  logic               lat_en;
  logic [CLIENTS-1:0] hit;
  logic [LINE_W-1:0]  line_inc;
  logic [RD_W-1:0]    rd;
  logic               err;
  logic [CLIENTS-1:0] lat;
  logic [CLIENTS-1:0] pend;

  assign advance     = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  assign in_ev_ok = 32'(req_i.event_id) < EVENTS;
  assign in_addr  = in_ev_ok ? EV_AW'(req_i.event_id) : '0;

  always_comb begin
    mask_d   = mask_q;
    flags_d  = flags_q;
    match_d  = match_q;
    line_d   = line_q;
    cvalid_d = cvalid_q;
    wr_en    = 1'b0;
    rd       = '0;
    err      = 1'b0;
    lat      = '0;
    lat_en   = 1'b0;
    hit      = '1;
    any_en   = '0;
    line_inc = line_q + LINE_W'(1);
    new_mask = s1_item_q.val[EVENTS-1:0];

    ev_ok = 32'(s1_item_q.ev) < EVENTS;
    ea    = ev_ok ? EV_AW'(s1_item_q.ev) : '0;
    have  = 32'(s1_item_q.client) < CLIENTS;
    ca    = CL_AW'(s1_item_q.client);

    for (int k = 0; k < CLIENTS; k++) begin
      any_en |= mask_q[k];
      // A forwarded row is fully valid; otherwise an invalid lane reads as zero
      eff_row[k] = fwd_q ? fwd_row_q[k] : (cvalid_q[ea][k] ? rd_row_q[k] : '0);
    end
    wr_row = eff_row;
    diff   = mask_q[ca] ^ new_mask;

    case (s1_item_q.req)
      REQ_EVENT: begin
        if (!ev_ok) begin
          err = 1'b1;
        end else begin
          lat_en = 1'b1;
          if (ea == EV_AW'(FINISH_EVENT)) begin
            lat_en = !s1_item_q.busy;
          end else if (ea == EV_AW'(HSYNC_EVENT)) begin
            lat_en = any_en[HSYNC_EVENT];
            if (lat_en) begin
              line_d = line_inc;
            end
            for (int k = 0; k < CLIENTS; k++) begin
              hit[k] = match_q[k] == line_inc;
            end
          end else if (ea == EV_AW'(VSYNC_EVENT)) begin
            if (any_en[VSYNC_EVENT] || any_en[HSYNC_EVENT]) begin
              line_d = '0;
            end
          end
          for (int k = 0; k < CLIENTS; k++) begin
            lat[k] = lat_en && hit[k] && mask_q[k][ea];
            if (lat[k]) begin
              flags_d[k][ea] = 1'b1;
              wr_row[k]      = eff_row[k] + CNT_W'(1);
              wr_en          = 1'b1;
            end
          end
        end
      end
      REQ_SET_MASK: begin
        if (have) begin
          rd = RD_W'(mask_q[ca]);
          flags_d[ca] = flags_q[ca] & ~diff;
          for (int i = 0; i < EVENTS; i++) begin
            cvalid_d[i][ca] = cvalid_q[i][ca] & ~diff[i];
          end
          mask_d[ca] = new_mask;
        end
      end
      REQ_TAKE_FLAGS: begin
        if (have) begin
          rd = RD_W'(flags_q[ca]);
          flags_d[ca] = flags_q[ca] & ~new_mask;
        end
      end
      REQ_TAKE_COUNT: begin
        if (!ev_ok) begin
          err = 1'b1;
        end else if (have) begin
          rd         = RD_W'(eff_row[ca]);
          wr_row[ca] = '0;
          wr_en      = 1'b1;
        end
      end
      REQ_CLEAR_COUNTS: begin
        if (have) begin
          for (int i = 0; i < EVENTS; i++) begin
            cvalid_d[i][ca] = 1'b0;
          end
        end
      end
      REQ_SET_LINE: begin
        if (have) begin
          rd = RD_W'(match_q[ca]);
          match_d[ca] = LINE_W'(s1_item_q.val);
        end
      end
      REQ_READ_LINE: begin
        rd = RD_W'(line_q);
      end
      default: begin
      end
    endcase

    // A written row holds the effective value of every lane
    if (wr_en) begin
      cvalid_d[ea] = '1;
    end

    for (int k = 0; k < CLIENTS; k++) begin
      pend[k] = |(flags_d[k] & mask_d[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      mask_q      <= '0;
      flags_q     <= '0;
      match_q     <= '0;
      line_q      <= '0;
      cvalid_q    <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (accept) begin
        // Forward the row being written at this edge to the word reading it
        fwd_q <= advance && wr_en && (ea == in_addr);
      end
      if (advance) begin
        mask_q      <= mask_d;
        flags_q     <= flags_d;
        match_q     <= match_d;
        line_q      <= line_d;
        cvalid_q    <= cvalid_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= item_t'{
        req:    req_e'(req_i.req_type),
        client: req_i.client,
        ev:     req_i.event_id,
        busy:   req_i.store_busy,
        val:    req_i.value
      };
      fwd_row_q <= wr_row;
    end
    if (advance) begin
      rsp_rd_q   <= rd;
      rsp_err_q  <= err;
      rsp_lat_q  <= lat;
      rsp_pend_q <= pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && wr_en) begin
      cnt_mem[ea] <= wr_row;
    end
    if (accept) begin
      rd_row_q <= cnt_mem[in_addr];
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.read_data       = rsp_rd_q;
  assign rsp_o.error           = rsp_err_q;
  assign rsp_o.latched_clients = rsp_lat_q;
  assign rsp_o.pending_clients = rsp_pend_q;

endmodule

FILE: design/elcu_checker.sv
module elcu_checker import elcu_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [RD_W-1:0]    read_data_i,
  input logic               error_i,
  input logic [CLIENTS-1:0] latched_i,
  input logic [CLIENTS-1:0] pending_i
);

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(read_data_i) && $stable(error_i)
      && $stable(latched_i) && $stable(pending_i))
    else $error("response changed while stalled");

  // A bad event index changes nothing and reads zero
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && error_i |-> read_data_i == '0 && latched_i == '0)
    else $error("error response carries data");

  // A client that just latched an enabled event must be pending
  a_lat_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (latched_i & ~pending_i) == '0)
    else $error("latched client not pending");

endmodule

bind event_latch_counter_unit_top elcu_checker u_elcu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .read_data_i (rsp_o.read_data),
  .error_i     (rsp_o.error),
  .latched_i   (rsp_o.latched_clients),
  .pending_i   (rsp_o.pending_clients)
);
